// ===== design/im2col_pkg.sv =====
// Shared types, codes and default limits of the im2col address generator.
package im2col_pkg;

  // Default limits, handed to the top level parameters
  localparam int MAX_DIM_DEF    = 1024;
  localparam int MAX_KERNEL_DEF = 8;
  localparam int ADDR_BITS_DEF  = 32;

  // Fixed field and port widths
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 3;
  localparam int BASE_W    = 32;

  // Queue depths
  localparam int CMD_DEPTH = 4;
  localparam int RES_DEPTH = 4;

  // Item opcodes
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNELS,
    REG_IN_HEIGHT,
    REG_IN_WIDTH,
    REG_KERNEL_DIMS,
    REG_STRIDES,
    REG_PADDINGS,
    REG_OUT_HEIGHT,
    REG_OUT_WIDTH
  } reg_idx_t;

  // Decoded item, front to back
  typedef struct packed {
    logic              is_start;
    logic [BASE_W-1:0] src_base;
    logic [BASE_W-1:0] dst_base;
  } cmd_t;

  // Configuration write
  typedef struct packed {
    logic                 write;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;
  } cfg_wr_t;

endpackage

// ===== design/im2col_address_generator.sv =====
// Top level of the im2col address generator: front, back and result queue.
//
// Usage: the input side is a queue. An item is taken when push is high and
// full is low. op = start latches src_base/dst_base and begins a job; op =
// step yields one element move (ignored while no job runs). Moves walk
// channel, output row, output column, kernel row, kernel column.
// Results come out of a queue: while empty is low the oldest move is on
// src_addr/dst_addr/zero_fill/last, and pop takes it. last marks the final
// move of a job, after which steps are ignored until the next start.
// Configuration is written through cfg_write/cfg_index/cfg_data, one
// register per cycle, while no items are in flight.
// Path to empty falling: command queue, walk counters, four-stage address
// pipeline with at most three small multiplies per stage, result queue.
// Throughput: one item per cycle while the pipeline is not held.
// When the receiver stops popping, the result queue fills, the pipeline
// holds, the command queue fills and full rises; nothing is dropped.
// Reset (rst, synchronous) empties both queues, clears the walk state, ends
// any job and sets the registers to their defaults.
module im2col_address_generator #(
  parameter int MAX_DIM    = im2col_pkg::MAX_DIM_DEF,
  parameter int MAX_KERNEL = im2col_pkg::MAX_KERNEL_DEF,
  parameter int ADDR_BITS  = im2col_pkg::ADDR_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic                             op,
  input  logic [im2col_pkg::BASE_W-1:0]    src_base,
  input  logic [im2col_pkg::BASE_W-1:0]    dst_base,
  input  logic                             cfg_write,
  input  logic [im2col_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [im2col_pkg::CFG_W-1:0]     cfg_data,
  output logic                             empty,
  input  logic                             pop,
  output logic [ADDR_BITS-1:0]             src_addr,
  output logic [ADDR_BITS-1:0]             dst_addr,
  output logic                             zero_fill,
  output logic                             last
);
  import im2col_pkg::*;

  localparam int RES_W = 2 * ADDR_BITS + 2;

  cfg_wr_t              cfg_wr;
  cmd_t                 cmd;
  logic                 cmd_empty;
  logic                 cmd_pop;
  logic                 res_valid;
  logic                 res_full;
  logic [ADDR_BITS-1:0] res_src, res_dst;
  logic                 res_fill, res_last;
  logic [RES_W-1:0]     res_rd;

  always_comb begin
    cfg_wr.write = cfg_write;
    cfg_wr.index = cfg_index;
    cfg_wr.data  = cfg_data;
  end

  // Input decode and command queue
  im2col_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .op        (op),
    .src_base  (src_base),
    .dst_base  (dst_base),
    .cmd       (cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop)
  );

  // Walk and address computation
  im2col_back #(
    .MAX_DIM    (MAX_DIM),
    .MAX_KERNEL (MAX_KERNEL),
    .ADDR_BITS  (ADDR_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_wr),
    .cmd       (cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_valid (res_valid),
    .res_ready (!res_full),
    .res_src   (res_src),
    .res_dst   (res_dst),
    .res_fill  (res_fill),
    .res_last  (res_last)
  );

  // Result queue
  im2col_fifo #(
    .WIDTH (RES_W),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data ({res_src, res_dst, res_fill, res_last}),
    .full      (res_full),
    .pop       (pop),
    .pop_data  (res_rd),
    .empty     (empty)
  );

  assign src_addr  = res_rd[RES_W-1 -: ADDR_BITS];
  assign dst_addr  = res_rd[ADDR_BITS+1 -: ADDR_BITS];
  assign zero_fill = res_rd[1];
  assign last      = res_rd[0];

endmodule

// ===== design/im2col_fifo.sv =====
// Small register-based FIFO used for the command and result queues.
module im2col_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_data = mem[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== design/im2col_front.sv =====
// Front end: accepts input items, decodes the opcode and queues commands.
module im2col_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  logic                                  op,
  input  logic [im2col_pkg::BASE_W-1:0]         src_base,
  input  logic [im2col_pkg::BASE_W-1:0]         dst_base,
  output im2col_pkg::cmd_t                      cmd,
  output logic                                  cmd_empty,
  input  logic                                  cmd_pop
);
  import im2col_pkg::*;

  cmd_t                cmd_in;
  logic [$bits(cmd_t)-1:0] cmd_bits;

  // Decode the item
  always_comb begin
    cmd_in.is_start = (op == OP_START);
    cmd_in.src_base = src_base;
    cmd_in.dst_base = dst_base;
  end

  // Command queue toward the back end
  im2col_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (cmd_in),
    .full      (full),
    .pop       (cmd_pop),
    .pop_data  (cmd_bits),
    .empty     (cmd_empty)
  );

  assign cmd = cmd_t'(cmd_bits);

endmodule

// ===== design/im2col_back.sv =====
// Back end: config registers, walk counters and the address pipeline.
module im2col_back #(
  parameter int MAX_DIM    = im2col_pkg::MAX_DIM_DEF,
  parameter int MAX_KERNEL = im2col_pkg::MAX_KERNEL_DEF,
  parameter int ADDR_BITS  = im2col_pkg::ADDR_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  im2col_pkg::cfg_wr_t   cfg,
  input  im2col_pkg::cmd_t      cmd,
  input  logic                  cmd_empty,
  output logic                  cmd_pop,
  output logic                  res_valid,
  input  logic                  res_ready,
  output logic [ADDR_BITS-1:0]  res_src,
  output logic [ADDR_BITS-1:0]  res_dst,
  output logic                  res_fill,
  output logic                  res_last
);
  import im2col_pkg::*;

  localparam int DIM_LIM = (MAX_DIM > (1 << CFG_W) - 1) ? (1 << CFG_W) - 1 : MAX_DIM;
  localparam int KLIM    = (MAX_KERNEL > 8) ? 8 : MAX_KERNEL;
  localparam int IDX_W   = $clog2(DIM_LIM);
  localparam int KIDX_W  = (KLIM > 1) ? $clog2(KLIM) : 1;
  localparam int POS_W   = CFG_W + 6;
  localparam int AS_W    = IDX_W + 12;
  localparam int BS_W    = AS_W + 12;
  localparam int AD_W    = IDX_W + 8;
  localparam int BD_W    = AD_W + 12;
  localparam int CD_W    = BD_W + 12;
  localparam logic [CFG_W-1:0] DIM_MAX_V = CFG_W'(DIM_LIM);
  localparam logic [3:0]       KMAX_V    = 4'(KLIM);

  // Zero reads as one, oversize clamps to the limit
  function automatic logic [CFG_W-1:0] dim_of(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (v > DIM_MAX_V) begin
      r = DIM_MAX_V;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [3:0] ksize_of(input logic [2:0] v);
    logic [3:0] k;
    k = {1'b0, v} + 4'd1;
    if (k > KMAX_V) begin
      k = KMAX_V;
    end
    return k;
  endfunction

  // Configuration registers
  logic [CFG_W-1:0] channels, in_height, in_width, out_height, out_width;
  logic [5:0]       kernel_dims, strides, paddings;

  always_ff @(posedge clk) begin
    if (rst) begin
      channels    <= CFG_W'(1);
      in_height   <= CFG_W'(1);
      in_width    <= CFG_W'(1);
      kernel_dims <= '0;
      strides     <= '0;
      paddings    <= '0;
      out_height  <= CFG_W'(1);
      out_width   <= CFG_W'(1);
    end else if (cfg.write) begin
      case (reg_idx_t'(cfg.index))
        REG_CHANNELS:    channels    <= cfg.data;
        REG_IN_HEIGHT:   in_height   <= cfg.data;
        REG_IN_WIDTH:    in_width    <= cfg.data;
        REG_KERNEL_DIMS: kernel_dims <= cfg.data[5:0];
        REG_STRIDES:     strides     <= cfg.data[5:0];
        REG_PADDINGS:    paddings    <= cfg.data[5:0];
        REG_OUT_HEIGHT:  out_height  <= cfg.data;
        REG_OUT_WIDTH:   out_width   <= cfg.data;
        default: ;
      endcase
    end
  end

  // Effective sizes
  logic [CFG_W-1:0] n_ch, n_ih, n_iw, n_oh, n_ow;
  logic [3:0]       kw, kh, sx, sy;
  logic [2:0]       px, py;
  logic [6:0]       khkw;

  always_comb begin
    n_ch = dim_of(channels);
    n_ih = dim_of(in_height);
    n_iw = dim_of(in_width);
    n_oh = dim_of(out_height);
    n_ow = dim_of(out_width);
    kw   = ksize_of(kernel_dims[2:0]);
    kh   = ksize_of(kernel_dims[5:3]);
    sx   = {1'b0, strides[2:0]} + 4'd1;
    sy   = {1'b0, strides[5:3]} + 4'd1;
    px   = paddings[2:0];
    py   = paddings[5:3];
    khkw = 7'(kh) * 7'(kw);
  end

  // Walk state
  logic [IDX_W-1:0]     chan_idx, row_idx, col_idx;
  logic [KIDX_W-1:0]    krow_idx, kcol_idx;
  logic [IDX_W-1:0]     chan_idx_next, row_idx_next, col_idx_next;
  logic [KIDX_W-1:0]    krow_idx_next, kcol_idx_next;
  logic                 running, running_next;
  logic [ADDR_BITS-1:0] src_origin, dst_origin;

  // Pipeline valids
  logic v1, v2, v3, v4;
  logic pipe_en;
  logic step;

  // Window position and end flags of the current move
  logic [POS_W-1:0] ih, iw;
  logic             fill;
  logic             end_kc, end_kr, end_c, end_r, end_ch, last;

  assign pipe_en = !v4 || res_ready;
  assign cmd_pop = !cmd_empty && pipe_en;
  assign step    = cmd_pop && !cmd.is_start && running;

  always_comb begin
    ih     = POS_W'(row_idx) * POS_W'(sy) + POS_W'(krow_idx) - POS_W'(py);
    iw     = POS_W'(col_idx) * POS_W'(sx) + POS_W'(kcol_idx) - POS_W'(px);
    // a negative position wraps to a large unsigned value, so one compare covers both sides
    fill   = (ih >= POS_W'(n_ih)) || (iw >= POS_W'(n_iw));
    end_kc = (5'(kcol_idx) + 5'd1) >= 5'(kw);
    end_kr = (5'(krow_idx) + 5'd1) >= 5'(kh);
    end_c  = (12'(col_idx) + 12'd1) >= 12'(n_ow);
    end_r  = (12'(row_idx) + 12'd1) >= 12'(n_oh);
    end_ch = (12'(chan_idx) + 12'd1) >= 12'(n_ch);
    last   = end_kc && end_kr && end_c && end_r && end_ch;
  end

  // Counter advance, innermost kernel column first
  always_comb begin
    chan_idx_next = chan_idx;
    row_idx_next  = row_idx;
    col_idx_next  = col_idx;
    krow_idx_next = krow_idx;
    kcol_idx_next = kcol_idx;
    running_next  = running;
    if (cmd_pop && cmd.is_start) begin
      chan_idx_next = '0;
      row_idx_next  = '0;
      col_idx_next  = '0;
      krow_idx_next = '0;
      kcol_idx_next = '0;
      running_next  = 1'b1;
    end else if (step) begin
      if (last) begin
        chan_idx_next = '0;
        row_idx_next  = '0;
        col_idx_next  = '0;
        krow_idx_next = '0;
        kcol_idx_next = '0;
        running_next  = 1'b0;
      end else if (!end_kc) begin
        kcol_idx_next = kcol_idx + KIDX_W'(1);
      end else begin
        kcol_idx_next = '0;
        if (!end_kr) begin
          krow_idx_next = krow_idx + KIDX_W'(1);
        end else begin
          krow_idx_next = '0;
          if (!end_c) begin
            col_idx_next = col_idx + IDX_W'(1);
          end else begin
            col_idx_next = '0;
            if (!end_r) begin
              row_idx_next = row_idx + IDX_W'(1);
            end else begin
              row_idx_next  = '0;
              chan_idx_next = chan_idx + IDX_W'(1);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chan_idx   <= '0;
      row_idx    <= '0;
      col_idx    <= '0;
      krow_idx   <= '0;
      kcol_idx   <= '0;
      running    <= 1'b0;
      src_origin <= '0;
      dst_origin <= '0;
    end else begin
      chan_idx <= chan_idx_next;
      row_idx  <= row_idx_next;
      col_idx  <= col_idx_next;
      krow_idx <= krow_idx_next;
      kcol_idx <= kcol_idx_next;
      running  <= running_next;
      if (cmd_pop && cmd.is_start) begin
        src_origin <= ADDR_BITS'(cmd.src_base);
        dst_origin <= ADDR_BITS'(cmd.dst_base);
      end
    end
  end

  // Address pipeline payload
  logic [IDX_W-1:0]     c1, r1, oc1, r2, oc2, oc3;
  logic [KIDX_W-1:0]    kr1, kc1;
  logic [CFG_W-1:0]     ih1, iw1, iw2;
  logic                 fill1, fill2, fill3, fill4;
  logic                 last1, last2, last3, last4;
  logic [ADDR_BITS-1:0] so1, so2, so3, do1, do2, do3, do4, src4;
  logic [AS_W-1:0]      a_s2;
  logic [AD_W-1:0]      a_d2;
  logic [BS_W-1:0]      b_s3;
  logic [BD_W-1:0]      b_d3;
  logic [CD_W-1:0]      c_d4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (pipe_en) begin
      v1 <= step;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      // stage 1: snapshot of the move
      c1    <= chan_idx;
      r1    <= row_idx;
      oc1   <= col_idx;
      kr1   <= krow_idx;
      kc1   <= kcol_idx;
      ih1   <= ih[CFG_W-1:0];
      iw1   <= iw[CFG_W-1:0];
      fill1 <= fill;
      last1 <= last;
      so1   <= src_origin;
      do1   <= dst_origin;
      // stage 2: channel row offset, column plane index
      a_s2  <= AS_W'(c1) * AS_W'(n_ih) + AS_W'(ih1);
      a_d2  <= AD_W'(c1) * AD_W'(khkw) + AD_W'(kr1) * AD_W'(kw) + AD_W'(kc1);
      iw2   <= iw1;
      r2    <= r1;
      oc2   <= oc1;
      fill2 <= fill1;
      last2 <= last1;
      so2   <= so1;
      do2   <= do1;
      // stage 3: scale by widths and rows
      b_s3  <= BS_W'(a_s2) * BS_W'(n_iw) + BS_W'(iw2);
      b_d3  <= BD_W'(a_d2) * BD_W'(n_oh) + BD_W'(r2);
      oc3   <= oc2;
      fill3 <= fill2;
      last3 <= last2;
      so3   <= so2;
      do3   <= do2;
      // stage 4: source address done, last destination scale
      src4  <= fill3 ? '0 : so3 + ADDR_BITS'(b_s3);
      c_d4  <= CD_W'(b_d3) * CD_W'(n_ow) + CD_W'(oc3);
      fill4 <= fill3;
      last4 <= last3;
      do4   <= do3;
    end
  end

  assign res_valid = v4;
  assign res_src   = src4;
  assign res_dst   = do4 + ADDR_BITS'(c_d4);
  assign res_fill  = fill4;
  assign res_last  = last4;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the im2col address generator: directed and random im2col jobs.
module tb_top;
  import im2col_pkg::*;

  localparam int NUM_REGS       = 8;
  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 4000;

  // One element move as seen on the result ports
  typedef struct packed {
    logic [ADDR_BITS_DEF-1:0] src_addr;
    logic [ADDR_BITS_DEF-1:0] dst_addr;
    logic                     zero_fill;
    logic                     last;
  } move_t;

  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     push      = 1'b0;
  logic                     op        = OP_START;
  logic [BASE_W-1:0]        src_base  = '0;
  logic [BASE_W-1:0]        dst_base  = '0;
  logic                     cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_W-1:0]         cfg_data  = '0;
  logic                     pop       = 1'b0;
  logic                     full;
  logic                     empty;
  logic [ADDR_BITS_DEF-1:0] src_addr;
  logic [ADDR_BITS_DEF-1:0] dst_addr;
  logic                     zero_fill;
  logic                     last;

  // Local copy of the walk state and the register file
  logic [CFG_W-1:0]  shadow_cfg [NUM_REGS];
  logic [CFG_W-1:0]  next_cfg [NUM_REGS];
  int                chan_i, row_i, col_i, krow_i, kcol_i;
  logic [BASE_W-1:0] src_org, dst_org;
  bit                job_active;

  move_t expected_moves [$];
  move_t head_move;
  int    errors        = 0;
  int    send_idle_pct = 37;
  int    recv_idle_pct = 51;
  int    quiet_cycles  = 0;

  im2col_address_generator i_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .op        (op),
    .src_base  (src_base),
    .dst_base  (dst_base),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .empty     (empty),
    .pop       (pop),
    .src_addr  (src_addr),
    .dst_addr  (dst_addr),
    .zero_fill (zero_fill),
    .last      (last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Dimension registers: zero reads as 1, oversize clamps to the maximum
  function automatic longint eff_dim(input logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
    return longint'(v);
  endfunction

  function automatic longint eff_kernel(input logic [2:0] v);
    longint k;
    k = longint'(v) + 1;
    return (k > MAX_KERNEL_DEF) ? MAX_KERNEL_DEF : k;
  endfunction

  function automatic void clear_walk();
    chan_i = 0;
    row_i  = 0;
    col_i  = 0;
    krow_i = 0;
    kcol_i = 0;
  endfunction

  // Moves in a full job under the current register settings
  function automatic longint planned_moves();
    return eff_dim(shadow_cfg[REG_CHANNELS]) * eff_dim(shadow_cfg[REG_OUT_HEIGHT]) *
           eff_dim(shadow_cfg[REG_OUT_WIDTH]) *
           eff_kernel(shadow_cfg[REG_KERNEL_DIMS][2:0]) *
           eff_kernel(shadow_cfg[REG_KERNEL_DIMS][5:3]);
  endfunction

  // Advance the local walk for one accepted item and queue the move it yields
  function automatic void walk_step(input logic op_i, input logic [BASE_W-1:0] sb,
                                    input logic [BASE_W-1:0] db);
    longint nch, ihn, iwn, kw, kh, sx, sy, px, py, oh, ow, ih, iw, plane;
    logic [63:0] src_full, dst_full;
    logic fill, end_kc, end_kr, end_c, end_r, end_ch, fin;
    move_t mv;
    if (op_i == OP_START) begin
      src_org    = sb;
      dst_org    = db;
      clear_walk();
      job_active = 1'b1;
      return;
    end
    if (!job_active) return;

    nch = eff_dim(shadow_cfg[REG_CHANNELS]);
    ihn = eff_dim(shadow_cfg[REG_IN_HEIGHT]);
    iwn = eff_dim(shadow_cfg[REG_IN_WIDTH]);
    kw  = eff_kernel(shadow_cfg[REG_KERNEL_DIMS][2:0]);
    kh  = eff_kernel(shadow_cfg[REG_KERNEL_DIMS][5:3]);
    sx  = longint'(shadow_cfg[REG_STRIDES][2:0]) + 1;
    sy  = longint'(shadow_cfg[REG_STRIDES][5:3]) + 1;
    px  = longint'(shadow_cfg[REG_PADDINGS][2:0]);
    py  = longint'(shadow_cfg[REG_PADDINGS][5:3]);
    oh  = eff_dim(shadow_cfg[REG_OUT_HEIGHT]);
    ow  = eff_dim(shadow_cfg[REG_OUT_WIDTH]);

    // Padded window position, zero fill outside the image
    ih   = row_i * sy - py + krow_i;
    iw   = col_i * sx - px + kcol_i;
    fill = (ih < 0) || (ih >= ihn) || (iw < 0) || (iw >= iwn);

    src_full = fill ? 64'd0 : longint'(src_org) + (chan_i * ihn + ih) * iwn + iw;
    plane    = chan_i * kh * kw + krow_i * kw + kcol_i;
    dst_full = longint'(dst_org) + (plane * oh + row_i) * ow + col_i;

    // An index at or past its limit counts as done and wraps
    end_kc = (kcol_i + 1 >= kw);
    end_kr = (krow_i + 1 >= kh);
    end_c  = (col_i + 1 >= ow);
    end_r  = (row_i + 1 >= oh);
    end_ch = (chan_i + 1 >= nch);
    fin    = end_kc && end_kr && end_c && end_r && end_ch;

    if (fin) begin
      clear_walk();
      job_active = 1'b0;
    end else if (!end_kc) begin
      kcol_i++;
    end else begin
      kcol_i = 0;
      if (!end_kr) begin
        krow_i++;
      end else begin
        krow_i = 0;
        if (!end_c) begin
          col_i++;
        end else begin
          col_i = 0;
          if (!end_r) begin
            row_i++;
          end else begin
            row_i = 0;
            chan_i++;
          end
        end
      end
    end

    mv.src_addr  = src_full[ADDR_BITS_DEF-1:0];
    mv.dst_addr  = dst_full[ADDR_BITS_DEF-1:0];
    mv.zero_fill = fill;
    mv.last      = fin;
    expected_moves.push_back(mv);
  endfunction

  // Offer one item, with random gaps before it, and wait until it is taken
  task automatic send_item(input logic op_i, input logic [BASE_W-1:0] sb,
                           input logic [BASE_W-1:0] db);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push     <= 1'b1;
    op       <= op_i;
    src_base <= sb;
    dst_base <= db;
    @(posedge clk);
    while (full) @(posedge clk);
    walk_step(op_i, sb, db);
  endtask

  // Stop sending, drain all moves, then let items with no move settle
  task automatic wait_idle();
    push <= 1'b0;
    while (expected_moves.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all registers from next_cfg once the block is idle
  task automatic load_config();
    wait_idle();
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= reg_idx_t'(i);
      cfg_data  <= next_cfg[i];
      @(posedge clk);
      if (i == REG_KERNEL_DIMS || i == REG_STRIDES || i == REG_PADDINGS)
        shadow_cfg[i] = next_cfg[i] & 11'h03f;
      else
        shadow_cfg[i] = next_cfg[i];
    end
    cfg_write <= 1'b0;
  endtask

  function automatic logic [CFG_W-1:0] pick_dim(input int hi);
    int r;
    r = $urandom_range(31);
    if (r == 0) return '0;
    if (r == 1) return CFG_W'($urandom_range(2047, MAX_DIM_DEF + 1));
    return CFG_W'($urandom_range(hi, 1));
  endfunction

  function automatic void randomize_config();
    next_cfg[REG_CHANNELS]  = pick_dim(3);
    next_cfg[REG_IN_HEIGHT] = pick_dim(9);
    next_cfg[REG_IN_WIDTH]  = pick_dim(9);
    // mostly small kernels so jobs run to their end
    if ($urandom_range(3) != 0)
      next_cfg[REG_KERNEL_DIMS] = CFG_W'($urandom_range(2) * 8 + $urandom_range(2));
    else
      next_cfg[REG_KERNEL_DIMS] = CFG_W'($urandom_range(63));
    next_cfg[REG_STRIDES]    = CFG_W'($urandom_range(63));
    next_cfg[REG_PADDINGS]   = CFG_W'($urandom_range(63));
    next_cfg[REG_OUT_HEIGHT] = pick_dim(4);
    next_cfg[REG_OUT_WIDTH]  = pick_dim(4);
  endfunction

  // Reset defaults give a 1x1 job of one move; a step with no job is dropped
  task automatic test_reset_defaults();
    send_item(OP_START, 32'hffff_ffff, 32'h0000_0000);
    send_item(OP_STEP, 32'h0000_0000, 32'h0000_0000);
    send_item(OP_STEP, 32'h1234_5678, 32'h9abc_def0);
    send_item(OP_START, 32'h0000_0000, 32'hffff_ffff);
    send_item(OP_STEP, 32'hffff_ffff, 32'hffff_ffff);
  endtask

  // Register extremes: zero and oversize dimensions, widest kernel, stride, padding
  task automatic test_extremes();
    next_cfg[REG_CHANNELS]    = 11'd2047;
    next_cfg[REG_IN_HEIGHT]   = 11'd0;
    next_cfg[REG_IN_WIDTH]    = 11'd1024;
    next_cfg[REG_KERNEL_DIMS] = 11'd63;
    next_cfg[REG_STRIDES]     = 11'd63;
    next_cfg[REG_PADDINGS]    = 11'd63;
    next_cfg[REG_OUT_HEIGHT]  = 11'd2047;
    next_cfg[REG_OUT_WIDTH]   = 11'd0;
    load_config();
    send_item(OP_START, 32'hffff_ffff, 32'hffff_ffff);
    repeat (4) send_item(OP_STEP, 32'h0000_0000, 32'h0000_0000);

    next_cfg[REG_CHANNELS]    = 11'd0;
    next_cfg[REG_IN_HEIGHT]   = 11'd2047;
    next_cfg[REG_IN_WIDTH]    = 11'd2047;
    next_cfg[REG_KERNEL_DIMS] = 11'd0;
    next_cfg[REG_STRIDES]     = 11'd0;
    next_cfg[REG_PADDINGS]    = 11'd0;
    next_cfg[REG_OUT_HEIGHT]  = 11'd1024;
    next_cfg[REG_OUT_WIDTH]   = 11'd1024;
    load_config();
    send_item(OP_START, 32'hffff_fffe, 32'hffff_fffd);
    repeat (4) send_item(OP_STEP, 32'hffff_ffff, 32'hffff_ffff);
  endtask

  // Restart while a job runs, then shrink the kernel and width mid-job
  task automatic test_special_cases();
    next_cfg[REG_CHANNELS]    = 11'd1;
    next_cfg[REG_IN_HEIGHT]   = 11'd3;
    next_cfg[REG_IN_WIDTH]    = 11'd3;
    next_cfg[REG_KERNEL_DIMS] = 11'o11;
    next_cfg[REG_STRIDES]     = 11'd0;
    next_cfg[REG_PADDINGS]    = 11'o11;
    next_cfg[REG_OUT_HEIGHT]  = 11'd2;
    next_cfg[REG_OUT_WIDTH]   = 11'd2;
    load_config();
    send_item(OP_START, 32'h0000_1000, 32'h0000_2000);
    repeat (3) send_item(OP_STEP, $urandom, $urandom);
    send_item(OP_START, 32'h8000_0000, 32'h4000_0000);
    repeat (5) send_item(OP_STEP, $urandom, $urandom);
    // kernel column and output column now sit past their new limits
    next_cfg[REG_KERNEL_DIMS] = 11'd0;
    next_cfg[REG_OUT_WIDTH]   = 11'd1;
    load_config();
    repeat (3) send_item(OP_STEP, $urandom, $urandom);
  endtask

  // Random jobs: mostly complete walks, some cut short, some stray steps
  task automatic test_random(input int s_pct, input int r_pct, input int n_items);
    int     sent, steps;
    longint job_moves;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    sent          = 0;
    while (sent < n_items) begin
      if (sent == 0 || $urandom_range(3) == 0) begin
        randomize_config();
        load_config();
      end
      job_moves = planned_moves();
      steps     = int'(job_moves > 200 ? 200 : job_moves);
      if (job_moves > 200 || $urandom_range(7) == 0)
        steps = $urandom_range(1, steps > 60 ? 60 : steps);
      send_item(OP_START, $urandom, $urandom);
      repeat (steps) send_item(OP_STEP, $urandom, $urandom);
      sent += steps + 1;
      // steps after the last move are dropped by the block
      if (steps == job_moves && $urandom_range(7) == 0)
        repeat ($urandom_range(3, 1)) send_item(OP_STEP, $urandom, $urandom);
    end
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Result side: compare each popped move, then pick next cycle's pop
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (expected_moves.size() == 0) begin
        $display("%0t: unexpected move, expected none, actual src %h dst %h",
                 $time, src_addr, dst_addr);
        errors++;
      end else begin
        head_move = expected_moves.pop_front();
        check_field("src_addr", head_move.src_addr, src_addr);
        check_field("dst_addr", head_move.dst_addr, dst_addr);
        check_field("zero_fill", 32'(head_move.zero_fill), 32'(zero_fill));
        check_field("last", 32'(head_move.last), 32'(last));
      end
    end
    pop <= !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog on cycles with no item taken on either side
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    shadow_cfg[REG_CHANNELS]    = 11'd1;
    shadow_cfg[REG_IN_HEIGHT]   = 11'd1;
    shadow_cfg[REG_IN_WIDTH]    = 11'd1;
    shadow_cfg[REG_KERNEL_DIMS] = 11'd0;
    shadow_cfg[REG_STRIDES]     = 11'd0;
    shadow_cfg[REG_PADDINGS]    = 11'd0;
    shadow_cfg[REG_OUT_HEIGHT]  = 11'd1;
    shadow_cfg[REG_OUT_WIDTH]   = 11'd1;
    clear_walk();
    job_active = 1'b0;
    src_org    = '0;
    dst_org    = '0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_extremes();
    test_special_cases();
    test_random(37, 51, 340);
    test_random(51, 37, 340);
    test_random(0, 0, 340);
    wait_idle();

    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/im2col_pkg.sv
design/im2col_fifo.sv
design/im2col_front.sv
design/im2col_back.sv
design/im2col_address_generator.sv
bench/tb_top.sv
